/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define IHEX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define IHEX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ihex_pkg.sv */
// Package with the types, constants and character functions of the Intel HEX encoder.
`default_nettype none
package ihex_pkg;

  localparam int BYTES_PER_RECORD = 16;
  localparam int POS_W            = $clog2(BYTES_PER_RECORD);
  localparam int JOB_DEPTH        = 4;
  localparam int ADDR_W           = 16;
  localparam int COUNT_W          = 13;
  localparam int CHAR_W           = 7;
  localparam int SLOT_W           = 5;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = 16'h0000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd64;

  localparam logic CFG_IDX_BASE  = 1'b0;
  localparam logic CFG_IDX_COUNT = 1'b1;

  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
  localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;

  localparam logic [SLOT_W-1:0] SLOT_COLON     = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI    = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO    = 5'd2;
  localparam logic [SLOT_W-1:0] SLOT_ADDR3     = 5'd3;
  localparam logic [SLOT_W-1:0] SLOT_ADDR2     = 5'd4;
  localparam logic [SLOT_W-1:0] SLOT_ADDR1     = 5'd5;
  localparam logic [SLOT_W-1:0] SLOT_ADDR0     = 5'd6;
  localparam logic [SLOT_W-1:0] SLOT_TYPE_HI   = 5'd7;
  localparam logic [SLOT_W-1:0] SLOT_TYPE_LO   = 5'd8;
  localparam logic [SLOT_W-1:0] SLOT_DATA_HI   = 5'd9;
  localparam logic [SLOT_W-1:0] SLOT_DATA_LO   = 5'd10;
  localparam logic [SLOT_W-1:0] SLOT_SUM_HI    = 5'd11;
  localparam logic [SLOT_W-1:0] SLOT_SUM_LO    = 5'd12;
  localparam logic [SLOT_W-1:0] SLOT_REC_NL    = 5'd13;
  localparam logic [SLOT_W-1:0] SLOT_EOF_COLON = 5'd14;
  localparam logic [SLOT_W-1:0] SLOT_EOF_ONE   = 5'd22;
  localparam logic [SLOT_W-1:0] SLOT_EOF_F_HI  = 5'd23;
  localparam logic [SLOT_W-1:0] SLOT_EOF_F_LO  = 5'd24;
  localparam logic [SLOT_W-1:0] SLOT_EOF_NL    = 5'd25;

  localparam logic [7:0] REC_LEN = 8'(BYTES_PER_RECORD);

  typedef struct packed {
    logic [7:0]        data;
    logic              hdr;
    logic [ADDR_W-1:0] addr;
    logic              tail;
    logic [7:0]        csum;
    logic              eof;
  } job_t;

  typedef struct packed {
    logic               base_we;
    logic               count_we;
    logic [ADDR_W-1:0]  base;
    logic [COUNT_W-1:0] count;
  } cfg_wr_t;

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
    logic [CHAR_W-1:0] r;
    if (v < 4'd10) r = CH_ZERO + 7'(v);
    else r = 7'h37 + 7'(v);
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] slot_char(input logic [SLOT_W-1:0] slot,
                                                  input job_t j);
    logic [CHAR_W-1:0] c;
    case (slot)
      SLOT_COLON:     c = CH_COLON;
      SLOT_LEN_HI:    c = hex_digit(REC_LEN[7:4]);
      SLOT_LEN_LO:    c = hex_digit(REC_LEN[3:0]);
      SLOT_ADDR3:     c = hex_digit(j.addr[15:12]);
      SLOT_ADDR2:     c = hex_digit(j.addr[11:8]);
      SLOT_ADDR1:     c = hex_digit(j.addr[7:4]);
      SLOT_ADDR0:     c = hex_digit(j.addr[3:0]);
      SLOT_TYPE_HI:   c = CH_ZERO;
      SLOT_TYPE_LO:   c = CH_ZERO;
      SLOT_DATA_HI:   c = hex_digit(j.data[7:4]);
      SLOT_DATA_LO:   c = hex_digit(j.data[3:0]);
      SLOT_SUM_HI:    c = hex_digit(j.csum[7:4]);
      SLOT_SUM_LO:    c = hex_digit(j.csum[3:0]);
      SLOT_REC_NL:    c = CH_NL;
      SLOT_EOF_COLON: c = CH_COLON;
      SLOT_EOF_ONE:   c = CH_ONE;
      SLOT_EOF_F_HI:  c = CH_F;
      SLOT_EOF_F_LO:  c = CH_F;
      SLOT_EOF_NL:    c = CH_NL;
      default:        c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/intel_hex_record_encoder_top.sv */
// Top level of the Intel HEX data record encoder with its register port.
//
// Bytes go in through push/full and come out as Intel HEX text, one ASCII
// character per beat through empty/pop. The front end takes one byte per
// cycle until the job queue (JOB_DEPTH entries) is full; the serializer
// behind it writes one character per cycle while jobs wait and pop keeps up,
// so a byte yields 2 characters in the middle of a record, 11 for the first
// byte of a record, 5 for the last and 17 when the end-of-file record
// follows: 44 characters per 16-byte record, 2.75 per byte. The serializer's
// output register sets that rate. Register 0 at byte address 0 holds the base
// load address, register 1 at byte address 4 the record count; 0 means 8192.
`default_nettype none
module intel_hex_record_encoder_top
  import ihex_pkg::*;
#(
  parameter int JOB_DEPTH_P = JOB_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [CHAR_W-1:0] out_ascii_char,
  output logic             out_last_of_run,
  output logic             out_file_done,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_wr_t            cfg_wr;
  logic               wr_hit;
  logic               job_we;
  job_t               job_in, job_out;
  logic               q_valid, q_pop;
  logic [ADDR_W-1:0]  base_addr;
  logic [COUNT_W-1:0] rec_count;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & pready;

  always_comb begin
    cfg_wr.base_we  = wr_hit & (paddr[2] == CFG_IDX_BASE);
    cfg_wr.count_we = wr_hit & (paddr[2] == CFG_IDX_COUNT);
    cfg_wr.base     = pwdata[ADDR_W-1:0];
    cfg_wr.count    = pwdata[COUNT_W-1:0];
    if (paddr[2] == CFG_IDX_COUNT) prdata = {{(32-COUNT_W){1'b0}}, rec_count};
    else prdata = {{(32-ADDR_W){1'b0}}, base_addr};
  end

  ihex_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_wr),
    .push         (push),
    .q_full       (full),
    .in_data_byte (in_data_byte),
    .job_we       (job_we),
    .job          (job_in),
    .base_addr    (base_addr),
    .rec_count    (rec_count)
  );

  ihex_jobq #(
    .DEPTH (JOB_DEPTH_P)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_we),
    .wr_job   (job_in),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (job_out)
  );

  ihex_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (job_out),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_ascii_char  (out_ascii_char),
    .out_last_of_run (out_last_of_run),
    .out_file_done   (out_file_done)
  );

endmodule
`default_nettype wire

/* rtl/core/ihex_front.sv */
// Front end: takes image bytes, tracks record state and issues one job per byte.
`default_nettype none
module ihex_front
  import ihex_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg_wr,
  input  wire logic    push,
  input  wire logic    q_full,
  input  wire logic [7:0] in_data_byte,
  output logic         job_we,
  output job_t         job,
  output logic [ADDR_W-1:0]  base_addr,
  output logic [COUNT_W-1:0] rec_count
);

  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_W-1:0] done_r, done_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic               hdr, tail, eof;
  logic [7:0]         sum_base, sum_new;
  logic [COUNT_W-1:0] done_inc;

  assign job_we    = push & ~q_full;
  assign base_addr = base_r;
  assign rec_count = count_r;

  always_comb begin
    hdr      = (pos_r == '0);
    tail     = (pos_r == POS_W'(BYTES_PER_RECORD - 1));
    sum_base = hdr ? (REC_LEN + addr_r[15:8] + addr_r[7:0]) : sum_r;
    sum_new  = sum_base + in_data_byte;
    done_inc = done_r + 1'b1;
    eof      = tail & (done_inc == count_r);

    job.data = in_data_byte;
    job.hdr  = hdr;
    job.addr = addr_r;
    job.tail = tail;
    job.csum = 8'h00 - sum_new;
    job.eof  = eof;

    base_nxt  = base_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    pos_nxt   = pos_r;
    done_nxt  = done_r;
    sum_nxt   = sum_r;

    if (cfg_wr.base_we) begin
      base_nxt = cfg_wr.base;
      if (done_r == '0 && pos_r == '0) addr_nxt = cfg_wr.base;
    end
    if (cfg_wr.count_we) count_nxt = cfg_wr.count;

    if (job_we) begin
      if (tail) begin
        pos_nxt = '0;
        sum_nxt = 8'h00;
        if (eof) begin
          done_nxt = '0;
          addr_nxt = base_r;
        end else begin
          done_nxt = done_inc;
          addr_nxt = addr_r + ADDR_W'(BYTES_PER_RECORD);
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
        sum_nxt = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      count_r <= COUNT_RESET;
      addr_r  <= BASE_RESET;
      pos_r   <= '0;
      done_r  <= '0;
      sum_r   <= 8'h00;
    end else begin
      base_r  <= base_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      pos_r   <= pos_nxt;
      done_r  <= done_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ihex_jobq.sv */
// Short job queue between the front end and the character serializer.
`default_nettype none
module ihex_jobq
  import ihex_pkg::*;
#(
  parameter int DEPTH = JOB_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output logic      rd_valid,
  output job_t      rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ihex_back.sv */
// Back end: turns each job into its text characters, one beat per cycle unless stalled by pop.
`default_nettype none
module ihex_back
  import ihex_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      q_pop,
  input  wire logic pop,
  output logic      empty,
  output logic [CHAR_W-1:0] out_ascii_char,
  output logic      out_last_of_run,
  output logic      out_file_done
);

  logic              cur_valid_r, cur_valid_nxt;
  job_t              cur_r, cur_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              done_r, done_nxt;
  logic [SLOT_W-1:0] end_slot;
  logic              adv, at_end, load;

  assign empty           = ~out_valid_r;
  assign out_ascii_char  = char_r;
  assign out_last_of_run = last_r;
  assign out_file_done   = done_r;

  always_comb begin
    end_slot = cur_r.eof ? SLOT_EOF_NL : (cur_r.tail ? SLOT_REC_NL : SLOT_DATA_LO);
    at_end   = (slot_r == end_slot);
    adv      = cur_valid_r & (~out_valid_r | pop);
    load     = ~cur_valid_r | (adv & at_end);
    q_pop    = load & q_valid;

    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      char_nxt      = slot_char(slot_r, cur_r);
      last_nxt      = at_end;
      done_nxt      = (slot_r == SLOT_EOF_NL);
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end

    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    slot_nxt      = slot_r;
    if (load) begin
      cur_valid_nxt = q_valid;
      cur_nxt       = q_job;
      slot_nxt      = q_job.hdr ? SLOT_COLON : SLOT_DATA_HI;
    end else if (adv) begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    slot_r <= slot_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ihex_checker.sv */
// Port-level checker for the Intel HEX encoder and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module ihex_checker
  import ihex_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [CHAR_W-1:0] out_ascii_char,
  input wire logic        out_last_of_run,
  input wire logic        out_file_done
);

  `IHEX_ASSERT(a_done_is_last, clk, rst_n, (!empty && out_file_done) |-> out_last_of_run, "file end beat must close its run")
  `IHEX_ASSERT(a_done_is_nl, clk, rst_n, (!empty && out_file_done) |-> (out_ascii_char == CH_NL), "file end beat must be a newline")
  `IHEX_ASSERT(a_stall_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_ascii_char)), "stalled result beat changed")
  `IHEX_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty, "result side not empty after reset")

endmodule

bind intel_hex_record_encoder_top ihex_checker u_ihex_checker (.*);
`default_nettype wire
